/* rtl/core/pfl_pkg.sv */
// Shared types, constants and codes for the pool free-list allocator.
package pfl_pkg;

  localparam int unsigned POOL_BYTES  = 16384;
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned ALIGN_BYTES = 8;

  localparam int unsigned ALIGN_LOG2 = $clog2(ALIGN_BYTES);
  localparam int unsigned LINK_DEPTH = POOL_BYTES / ALIGN_BYTES;
  localparam int unsigned LINK_IDX_W = $clog2(LINK_DEPTH);

  localparam int unsigned REG_W  = 15;
  localparam int unsigned OFF_W  = 14;
  localparam int unsigned SUM_W  = REG_W + 1;
  localparam int unsigned LINK_W = OFF_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SUM_W-1:0] ALIGN_MASK = SUM_W'(ALIGN_BYTES - 1);
  localparam logic [SUM_W-1:0] PAGE_MASK  = SUM_W'(PAGE_BYTES - 1);
  localparam logic [SUM_W-1:0] POOL_LIMIT = SUM_W'(POOL_BYTES);

  typedef enum logic [1:0] {
    MODE_ALLOC    = 2'd0,
    MODE_FREE     = 2'd1,
    MODE_FREE_ALL = 2'd2,
    MODE_NOP      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_FREE_VAR   = 2'd2,
    ST_BAD_OFFSET = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEMENT_SIZE = 2'd0,
    CFG_CAPACITY     = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    mode_e             mode;
    logic [REG_W-1:0]  request_size;
    logic [OFF_W-1:0]  element_offset;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [OFF_W-1:0]  granted_offset;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } pfl_cmd_t;

endpackage

/* rtl/core/pfl_ctrl.sv */
// Control state machine: transaction capture, execute step and result handshake.
module pfl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pfl_pkg::pfl_cmd_t cmd_o
);
  import pfl_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.capture = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.exec    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_o.exec) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cmd_o.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_rose_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result appeared without an execute step");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && out_valid_q && !out_ready_i |=> (state_q == S_EXEC))
    else $error("execute step left while result register blocked");

  a_capture_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_EXEC) && !in_ready_o)
    else $error("captured transaction not executed");

endmodule

/* rtl/core/pfl_datapath.sv */
// Datapath: config registers, pool state, link store and result register.
module pfl_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pfl_pkg::pfl_cmd_t               cmd_i,
  input  logic                            cfg_we_i,
  input  logic [pfl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfl_pkg::REG_W-1:0]       cfg_data_i,
  input  pfl_pkg::in_item_t               in_item_i,
  output pfl_pkg::out_item_t              out_item_o
);
  import pfl_pkg::*;

  logic [REG_W-1:0]  element_size_q;
  logic [REG_W-1:0]  capacity_q;
  logic              head_valid_q, head_valid_d;
  logic [OFF_W-1:0]  head_q, head_d;
  logic [REG_W-1:0]  bump_q, bump_d;
  logic [REG_W-1:0]  committed_q, committed_d;

  in_item_t          req_q;
  logic [SUM_W-1:0]  el_q;
  logic [SUM_W-1:0]  eff_cap_q;
  out_item_t         out_q, out_d;

  logic [LINK_W-1:0] links [LINK_DEPTH];
  logic [LINK_W-1:0] rd_q;
  logic              wr_en;
  logic [LINK_IDX_W-1:0] wr_idx;
  logic [LINK_W-1:0] wr_data;

  logic [REG_W-1:0]  size_sel;
  logic [SUM_W-1:0]  el_d;
  logic [SUM_W-1:0]  cap_round;
  logic [SUM_W-1:0]  sum_bump;
  logic [SUM_W-1:0]  sum_comm;
  logic [SUM_W-1:0]  grown;
  logic              grow;

  assign out_item_o = out_q;

  // element size and page-rounded capacity settle at capture
  assign size_sel  = (element_size_q != '0) ? element_size_q : in_item_i.request_size;
  assign el_d      = (SUM_W'(size_sel) + ALIGN_MASK) & ~ALIGN_MASK;
  assign cap_round = (SUM_W'(capacity_q) + PAGE_MASK) & ~PAGE_MASK;

  assign sum_bump = SUM_W'(bump_q) + el_q;
  assign sum_comm = SUM_W'(committed_q) + el_q;
  assign grown    = (sum_comm + PAGE_MASK) & ~PAGE_MASK;
  assign grow     = sum_bump > SUM_W'(committed_q);

  always_comb begin
    head_valid_d = head_valid_q;
    head_d       = head_q;
    bump_d       = bump_q;
    committed_d  = committed_q;
    wr_en        = 1'b0;
    wr_idx       = LINK_IDX_W'(req_q.element_offset >> ALIGN_LOG2);
    wr_data      = {head_valid_q, head_q};
    out_d.status         = ST_OK;
    out_d.granted_offset = '0;
    unique case (req_q.mode)
      MODE_ALLOC: begin
        if (head_valid_q) begin
          out_d.granted_offset = head_q;
          head_valid_d         = rd_q[LINK_W-1];
          head_d               = rd_q[OFF_W-1:0];
        end else if (grow && (grown > eff_cap_q)) begin
          out_d.status = ST_NO_SPACE;
        end else begin
          if (grow) begin
            committed_d = REG_W'(grown);
          end
          if (SUM_W'(bump_q) >= POOL_LIMIT) begin
            out_d.status = ST_NO_SPACE;
          end else begin
            out_d.granted_offset = OFF_W'(bump_q);
            bump_d               = REG_W'(sum_bump);
          end
        end
      end
      MODE_FREE: begin
        if (element_size_q == '0) begin
          out_d.status = ST_FREE_VAR;
        end else if (REG_W'(req_q.element_offset) >= bump_q) begin
          out_d.status = ST_BAD_OFFSET;
        end else begin
          wr_en        = 1'b1;
          head_d       = req_q.element_offset;
          head_valid_d = 1'b1;
        end
      end
      MODE_FREE_ALL: begin
        head_valid_d = 1'b0;
        head_d       = '0;
        bump_d       = '0;
        committed_d  = '0;
      end
      MODE_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_size_q <= '0;
      capacity_q     <= REG_W'(POOL_BYTES);
      head_valid_q   <= 1'b0;
      head_q         <= '0;
      bump_q         <= '0;
      committed_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ELEMENT_SIZE) begin
          element_size_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_CAPACITY) begin
          capacity_q <= cfg_data_i;
        end
      end
      if (cmd_i.exec) begin
        head_valid_q <= head_valid_d;
        head_q       <= head_d;
        bump_q       <= bump_d;
        committed_q  <= committed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q     <= in_item_i;
      el_q      <= el_d;
      eff_cap_q <= (cap_round > POOL_LIMIT) ? POOL_LIMIT : cap_round;
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  // link store: next-head word per aligned slot, registered read at capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      links[wr_idx] <= wr_data;
    end
    if (cmd_i.capture) begin
      rd_q <= links[LINK_IDX_W'(head_q >> ALIGN_LOG2)];
    end
  end

  a_bump_in_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= committed_q)
    else $error("bump position beyond committed size");

  a_commit_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUM_W'(committed_q) <= POOL_LIMIT)
    else $error("committed size beyond pool");

  a_free_sets_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && wr_en |=> head_valid_q && (out_q.status == ST_OK))
    else $error("accepted free did not become head");

endmodule

/* rtl/core/pool_free_list_allocator.sv */
// Top level of the pool free-list allocator.
// Each transaction has a capture step and an execute step: the capture step registers the
// request and reads the link store at the current free-list head, and the execute step
// updates the pool state and loads the result register. A new transaction is taken only
// once the previous one has executed, and a captured one waits in the execute step while a
// result is held. The link store needs no clearing after reset. Config writes are always
// accepted and are meant for an idle block.
module pool_free_list_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pfl_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pfl_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pfl_pkg::REG_W-1:0]     cfg_data_i
);
  import pfl_pkg::*;

  pfl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  pfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  pfl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o)
  );

endmodule
